// ===== hdl/pd2b_pkg.sv =====
// shared types and constants for the packed decimal to binary converter
package pd2b_pkg;

	localparam int MAX_BYTES_DEF = 9;
	localparam int ACC_W         = 57;
	localparam int VALUE_W       = 58;
	localparam int CNT_W         = 4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_DIGIT = 2'd1,
		ST_BAD_SIGN  = 2'd2,
		ST_TOO_LONG  = 2'd3
	} status_t;

	localparam logic [3:0] SIGN_NEG_D = 4'hD;
	localparam logic [3:0] SIGN_NEG_B = 4'hB;
	localparam logic [3:0] SIGN_MIN   = 4'hA;
	localparam logic [3:0] DIGIT_MAX  = 4'h9;
	localparam logic [CNT_W-1:0] CNT_SAT = '1;

endpackage

// ===== hdl/packed_decimal_to_binary.sv =====
// packed decimal (bcd with trailing sign nibble) to signed binary converter
//
// usage: the field arrives on the s_axis channel one byte per beat, first
// byte first, with s_axis_tlast on the byte that carries the sign nibble.
// every byte but the last adds two digits to the running value; the last
// adds one digit and gives the sign. one result beat per field leaves on
// m_axis: the signed value in tdata and the status in tuser (0 ok, 1 bad
// digit, 2 bad sign, 3 field too long). on any error the value is zero.
// the last byte passes through one input register and its result through one
// result register.
// throughput: one byte per cycle while m_axis is not stalled; the x100 add
// into the accumulator is combinational.
// when m_axis stalls the result register holds and the input register
// takes one more byte, then s_axis_tready drops until the result leaves.
// reset clears the accumulator, byte count, error and both valid flags.
module packed_decimal_to_binary #(
	parameter int MAX_BYTES = pd2b_pkg::MAX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [57:0] value, [63:58] zero
	output logic [7:0]  m_axis_tuser    // [1:0] status, [7:2] zero
);
	import pd2b_pkg::*;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic [ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]   cnt_q;
	status_t            err_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	status_t            status_q;

	logic               en;
	logic               step;
	logic [3:0]         hi;
	logic [3:0]         lo;
	logic [CNT_W-1:0]   cnt_next;
	status_t            err_next;
	logic [ACC_W-1:0]   acc_x10;
	logic [ACC_W-1:0]   acc_x100;
	logic [ACC_W-1:0]   acc_next;
	logic [VALUE_W-1:0] value_next;
	logic               negative;

	assign en            = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && en;
	assign s_axis_tready = en || !valid_s1;

	assign hi = byte_s1[7:4];
	assign lo = byte_s1[3:0];

	always_comb begin
		cnt_next = (cnt_q != CNT_SAT) ? cnt_q + 1'b1 : cnt_q;
		err_next = err_q;
		if (err_next == ST_OK && cnt_next > CNT_W'(MAX_BYTES))
			err_next = ST_TOO_LONG;
		if (err_next == ST_OK && (hi > DIGIT_MAX || (!last_s1 && lo > DIGIT_MAX)))
			err_next = ST_BAD_DIGIT;
		if (err_next == ST_OK && last_s1 && lo < SIGN_MIN)
			err_next = ST_BAD_SIGN;
	end

	// x10 and x100 as shift-adds
	assign acc_x10  = (acc_q << 3) + (acc_q << 1);
	assign acc_x100 = (acc_q << 6) + (acc_q << 5) + (acc_q << 2);

	always_comb begin
		if (err_next != ST_OK)
			acc_next = acc_q;
		else if (last_s1)
			acc_next = acc_x10 + ACC_W'(hi);
		else
			acc_next = acc_x100 + ACC_W'({hi, 3'b000}) + ACC_W'({hi, 1'b0}) + ACC_W'(lo);
	end

	assign negative = (lo == SIGN_NEG_D) || (lo == SIGN_NEG_B);

	always_comb begin
		if (err_next != ST_OK)
			value_next = '0;
		else if (negative)
			value_next = -{1'b0, acc_next};
		else
			value_next = {1'b0, acc_next};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			err_q <= ST_OK;
		end else if (step) begin
			if (last_s1) begin
				acc_q <= '0;
				cnt_q <= '0;
				err_q <= ST_OK;
			end else begin
				acc_q <= acc_next;
				cnt_q <= cnt_next;
				err_q <= err_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			value_q  <= value_next;
			status_q <= err_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(64-VALUE_W){1'b0}}, value_q};
	assign m_axis_tuser  = {6'b0, status_q};

	// error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1:0] != ST_OK) |-> (m_axis_tdata[57:0] == '0))
		else $error("error result with nonzero value");

	// state returns to reset after the last byte
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> (acc_q == '0 && cnt_q == '0 && err_q == ST_OK))
		else $error("state not cleared after last byte");

	// input side stalls only while a byte is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with nothing held");

	// a non-last byte never produces a result
	a_nolast: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !last_s1 && !out_valid_q) |=> !m_axis_tvalid)
		else $error("result without last byte");

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the packed decimal to binary converter
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pd2b_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_REPORTS  = 10;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
	} conv_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [7:0]  m_axis_tuser;

	logic [ACC_W-1:0] acc_model;
	logic [CNT_W-1:0] cnt_model;
	status_t          err_model;

	conv_result_t results_due[$];
	conv_result_t got_due;
	int           mismatches;
	int           bytes_sent;
	int           idle_cycles;
	bit           quiet;
	int           stall_left;

	packed_decimal_to_binary i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// converter model, one accepted byte at a time
	task automatic fold_byte(input logic [7:0] b, input logic last);
		logic [3:0]         hi;
		logic [3:0]         lo;
		conv_result_t       res;
		hi = b[7:4];
		lo = b[3:0];
		if (cnt_model != CNT_SAT)
			cnt_model = cnt_model + 1'b1;
		if (cnt_model > MAX_BYTES_DEF && err_model == ST_OK)
			err_model = ST_TOO_LONG;
		if (hi > DIGIT_MAX && err_model == ST_OK)
			err_model = ST_BAD_DIGIT;
		if (!last && lo > DIGIT_MAX && err_model == ST_OK)
			err_model = ST_BAD_DIGIT;
		if (last && lo < SIGN_MIN && err_model == ST_OK)
			err_model = ST_BAD_SIGN;
		if (err_model == ST_OK) begin
			acc_model = acc_model * 57'd10 + hi;
			if (!last)
				acc_model = acc_model * 57'd10 + lo;
		end
		if (last) begin
			res.status = err_model;
			if (err_model != ST_OK)
				res.value = '0;
			else if (lo == SIGN_NEG_D || lo == SIGN_NEG_B)
				res.value = -{1'b0, acc_model};
			else
				res.value = {1'b0, acc_model};
			results_due.push_back(res);
			acc_model = '0;
			cnt_model = '0;
			err_model = ST_OK;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		fold_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_field(input byte_q_t f);
		foreach (f[i])
			send_byte(f[i], i == f.size() - 1);
	endtask

	task automatic idle_source();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// mostly well-formed fields, some with noise bytes, a few too long
	task automatic build_field(output byte_q_t f);
		int  len;
		int  r;
		bit  noisy;
		bit  nines;
		logic [3:0] d_hi;
		logic [3:0] d_lo;
		f = {};
		r = $urandom_range(0, 99);
		if (r < 8)
			len = $urandom_range(10, 20);
		else if (r < 30)
			len = $urandom_range(1, 3);
		else
			len = $urandom_range(1, MAX_BYTES_DEF);
		noisy = ($urandom_range(0, 99) < 15);
		nines = ($urandom_range(0, 99) < 10);
		for (int i = 0; i < len; i++) begin
			d_hi = nines ? 4'd9 : 4'($urandom_range(0, 9));
			if (i == len - 1)
				d_lo = 4'($urandom_range(10, 15));
			else
				d_lo = nines ? 4'd9 : 4'($urandom_range(0, 9));
			if (noisy && $urandom_range(0, 99) < 20)
				f.push_back(8'($urandom_range(0, 255)));
			else
				f.push_back({d_hi, d_lo});
		end
	endtask

	task automatic test_signs_and_extremes();
		send_field('{8'h0C});
		send_field('{8'h9D});
		send_field('{8'h00, 8'h0D});
		send_field('{8'h1A});
		send_field('{8'h2B});
		send_field('{8'h3E});
		send_field('{8'h4F});
		send_field('{8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h9C});
		send_field('{8'h12, 8'h3D});
	endtask

	task automatic test_errors();
		send_field('{8'hA0, 8'h1C});
		send_field('{8'h0A, 8'h1C});
		send_field('{8'hFF});
		send_field('{8'h05});
		// bad digit seen first, bad sign later is not reported
		send_field('{8'hA0, 8'h05});
	endtask

	task automatic test_random_fields(input int n_bytes);
		byte_q_t f;
		int      stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			build_field(f);
			send_field(f);
		end
	endtask

	task automatic test_back_to_back(input int n_bytes);
		quiet = 1'b1;
		test_random_fields(n_bytes);
		quiet = 1'b0;
	endtask

	task automatic test_drain_pause(input int n_fields);
		byte_q_t f;
		for (int k = 0; k < n_fields; k++) begin
			build_field(f);
			send_field(f);
			idle_source();
			wait_drained();
		end
	endtask

	task automatic report(input string what, input logic [63:0] exp_v,
	                      input logic [63:0] act_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %s: expected %h, got %h at %0t", what, exp_v, act_v, $realtime);
	endtask

	// result beat checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (results_due.size() == 0) begin
				report("unexpected beat", 64'd0, m_axis_tdata);
			end else begin
				got_due = results_due.pop_front();
				if (m_axis_tdata[VALUE_W-1:0] !== got_due.value)
					report("value", 64'(got_due.value), 64'(m_axis_tdata[VALUE_W-1:0]));
				if (m_axis_tdata[63:VALUE_W] !== '0)
					report("tdata pad", 64'd0, 64'(m_axis_tdata[63:VALUE_W]));
				if (m_axis_tuser[1:0] !== got_due.status)
					report("status", 64'(got_due.status), 64'(m_axis_tuser[1:0]));
				if (m_axis_tuser[7:2] !== '0)
					report("tuser pad", 64'd0, 64'(m_axis_tuser[7:2]));
			end
		end
	end

	// result side back pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 99) < 25)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40)
				                                          : $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		acc_model     = '0;
		cnt_model     = '0;
		err_model     = ST_OK;
		mismatches    = 0;
		bytes_sent    = 0;
		quiet         = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_signs_and_extremes();
		test_errors();
		test_random_fields(240);
		test_drain_pause(20);
		test_back_to_back(150);
		test_random_fields(120);

		idle_source();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
